// ===== rtl/ippe_pkg.sv =====
// shared types and constants of the indexed pixel palette expander
// no dependencies; imported by the slicer, the top level and the testbench
package ippe_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int MAX_WIDTH       = 4096;
    localparam int PAL_ADDR_W      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int COL_W           = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DIM_W           = 13;
    localparam int CMP_W           = (($clog2(MAX_WIDTH + 1) > DIM_W) ?
                                      $clog2(MAX_WIDTH + 1) : DIM_W) + 1;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [1:0] {
        REQ_PAL   = 2'd0,
        REQ_ALPHA = 2'd1,
        REQ_DATA  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_DEPTH    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_USE_ALPHA    = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic [3:0]       bit_depth;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } cfg_t;

    // table lookup issued by the slicer, one per pixel
    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic       in_range;
        logic       last_of_byte;
        logic       row_end;
        logic       frame_end;
    } rd_req_t;

    // table update issued by the slicer
    typedef struct packed {
        logic                  pal_we;
        logic                  alpha_we;
        logic [PAL_ADDR_W-1:0] addr;
        logic [23:0]           rgb;
        logic [7:0]            alpha;
    } wr_req_t;

endpackage

// ===== rtl/ippe_req_if.sv =====
// input channel of the expander: table writes and stream bytes
// depends on nothing
interface ippe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic [23:0] entry_rgb;
    logic [7:0]  entry_alpha;
    logic [7:0]  data_byte;

    modport source (output valid, req_type, entry_index, entry_rgb, entry_alpha, data_byte,
                    input ready);
    modport sink   (input valid, req_type, entry_index, entry_rgb, entry_alpha, data_byte,
                    output ready);
endinterface

// ===== rtl/ippe_pix_if.sv =====
// output channel of the expander: one expanded pixel per word
// depends on nothing
interface ippe_pix_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_rgb;
    logic [7:0]  pixel_alpha;
    logic        last_of_byte;
    logic        row_end;
    logic        frame_end;

    modport source (output valid, pixel_rgb, pixel_alpha, last_of_byte, row_end, frame_end,
                    input ready);
    modport sink   (input valid, pixel_rgb, pixel_alpha, last_of_byte, row_end, frame_end,
                    output ready);
endinterface

// ===== rtl/ippe_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
module ippe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/ippe_slicer.sv =====
// holds the current input word, unpacks indices one per cycle unless stalled and tracks row position
// depends on ippe_pkg and ippe_req_if
module ippe_slicer (
    input  logic              clk,
    input  logic              rst_n,
    ippe_req_if.sink          req,
    input  ippe_pkg::cfg_t    cfg,
    input  logic              enable,
    output ippe_pkg::rd_req_t rd,
    output ippe_pkg::wr_req_t wr
);
    import ippe_pkg::*;

    logic             cur_valid_reg, cur_valid_next;
    logic [1:0]       cur_type_reg;
    logic [7:0]       cur_index_reg;
    logic [23:0]      cur_rgb_reg;
    logic [7:0]       cur_alpha_reg;
    logic [7:0]       cur_byte_reg, cur_byte_next;
    logic [2:0]       slot_reg, slot_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic             await_reg, await_next;
    logic             drop_reg, drop_next;

    logic [7:0]       pix_idx;
    logic [7:0]       byte_shifted;
    logic [2:0]       slot_max;
    logic [CMP_W-1:0] w_eff, h_eff, col_plus, row_plus;
    logic             rend, fend;
    logic             is_data, slot_work, step, slot_last, item_done, accept, idx_ok;

    always_comb
    begin
        case (cfg.bit_depth)
            4'd1:
            begin
                pix_idx      = {7'd0, cur_byte_reg[7]};
                byte_shifted = {cur_byte_reg[6:0], 1'b0};
                slot_max     = 3'd7;
            end
            4'd2:
            begin
                pix_idx      = {6'd0, cur_byte_reg[7:6]};
                byte_shifted = {cur_byte_reg[5:0], 2'b0};
                slot_max     = 3'd3;
            end
            4'd4:
            begin
                pix_idx      = {4'd0, cur_byte_reg[7:4]};
                byte_shifted = {cur_byte_reg[3:0], 4'b0};
                slot_max     = 3'd1;
            end
            default:
            begin
                pix_idx      = cur_byte_reg;
                byte_shifted = 8'd0;
                slot_max     = 3'd0;
            end
        endcase
    end

    // effective width and height with the out of range values folded in
    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (CMP_W'(cfg.image_width) > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CMP_W'(cfg.image_width);
        end
        h_eff    = (cfg.image_height == '0) ? CMP_W'(1) : CMP_W'(cfg.image_height);
        col_plus = CMP_W'(col_reg) + CMP_W'(1);
        row_plus = CMP_W'(row_reg) + CMP_W'(1);
        rend     = col_plus >= w_eff;
        fend     = rend && (row_plus >= h_eff);
    end

    assign is_data   = cur_type_reg == REQ_DATA;
    assign slot_work = cur_valid_reg && is_data && !await_reg;
    assign step      = cur_valid_reg && (!slot_work || drop_reg || enable);
    assign slot_last = rend || (slot_reg == slot_max);
    assign item_done = step && (!slot_work || slot_last);
    assign accept    = req.valid && req.ready;
    assign req.ready = !cur_valid_reg || item_done;
    assign idx_ok    = {1'b0, cur_index_reg} < 9'(PALETTE_ENTRIES);

    always_comb
    begin
        rd.en           = slot_work && !drop_reg && enable;
        rd.index        = pix_idx;
        rd.in_range     = {1'b0, pix_idx} < 9'(PALETTE_ENTRIES);
        rd.last_of_byte = slot_last;
        rd.row_end      = rend;
        rd.frame_end    = fend;

        wr.pal_we   = step && (cur_type_reg == REQ_PAL) && idx_ok;
        wr.alpha_we = step && (cur_type_reg == REQ_ALPHA) && idx_ok;
        wr.addr     = cur_index_reg[PAL_ADDR_W-1:0];
        wr.rgb      = cur_rgb_reg;
        wr.alpha    = cur_alpha_reg;
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_byte_next  = cur_byte_reg;
        slot_next      = slot_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        await_next     = await_reg;
        drop_next      = drop_reg;

        if (item_done)
        begin
            cur_valid_next = 1'b0;
        end

        if (step && is_data && await_reg)
        begin
            // filter byte opens a row
            await_next = 1'b0;
            drop_next  = cur_byte_reg != 8'd0;
            col_next   = '0;
        end
        else if (step && slot_work)
        begin
            slot_next     = slot_reg + 3'd1;
            cur_byte_next = byte_shifted;
            if (rend)
            begin
                col_next   = '0;
                await_next = 1'b1;
                row_next   = fend ? '0 : DIM_W'(row_plus);
            end
            else
            begin
                col_next = COL_W'(col_plus);
            end
        end

        if (accept)
        begin
            cur_valid_next = 1'b1;
            cur_byte_next  = req.data_byte;
            slot_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            await_reg     <= 1'b1;
            drop_reg      <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            slot_reg      <= slot_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            await_reg     <= await_next;
            drop_reg      <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
        if (accept)
        begin
            cur_type_reg  <= req.req_type;
            cur_index_reg <= req.entry_index;
            cur_rgb_reg   <= req.entry_rgb;
            cur_alpha_reg <= req.entry_alpha;
        end
    end
endmodule

// ===== rtl/indexed_pixel_palette_expander.sv =====
// top level of the indexed pixel palette expander: config registers, palette and
// alpha rams, lookup pipeline and output register
// depends on ippe_pkg, ippe_req_if, ippe_pix_if, ippe_ram and ippe_slicer

// Expands a PNG indexed-color data stream into RGB or RGBA pixels. Each input word
// is a palette write, an alpha write or one stream byte; every row starts with a
// filter byte, and rows whose filter is not none are consumed without output. A
// data byte at bit depth d yields 8/d pixels (fewer at the end of a row) and
// occupies the unpacker until the last of them is issued, one pixel per cycle
// while the output does not stall, because each pixel is one read of the single
// read port of the palette ram. Filter bytes, table writes and ignored words do
// no lookup; a byte of a dropped row walks its packed indices with no lookup and
// no wait on the output. A pixel's ram data is held in stage s1, then in the output
// register; the next input word is taken in the cycle the current one finishes,
// so a stalled output only holds the pipeline, never loses a word. Alpha entries
// read 255 until written, kept by one valid flop per entry; palette entries read
// undefined until written. No clearing pass is needed after reset. The user must
// write configuration only while the block is idle; the block does not enforce it.
module indexed_pixel_palette_expander (
    input  logic                           clk,
    input  logic                           rst_n,
    ippe_req_if.sink                       req,
    ippe_pix_if.source                     pix,
    input  logic                           cfg_we,
    input  logic [ippe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ippe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ippe_pkg::*;

    // configuration registers
    logic [3:0]       bit_depth_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             use_alpha_reg;
    cfg_t             cfg;

    // lookup pipeline: s1 holds the word whose ram data is on the read ports
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_in_range_reg;
    logic                  s1_alpha_ok_reg;
    logic                  s1_last_reg;
    logic                  s1_rend_reg;
    logic                  s1_fend_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [23:0]           out_rgb_reg;
    logic [7:0]            out_alpha_reg;
    logic                  out_last_reg;
    logic                  out_rend_reg;
    logic                  out_fend_reg;
    logic                  enable;

    logic [PALETTE_ENTRIES-1:0] alpha_vld_reg;
    rd_req_t                    rd;
    wr_req_t                    wr;
    logic [23:0]                pal_rdata;
    logic [7:0]                 alpha_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= 4'd8;
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
            use_alpha_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_DEPTH:    bit_depth_reg <= cfg_wdata[3:0];
                CFG_IMAGE_WIDTH:  width_reg     <= cfg_wdata[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg    <= cfg_wdata[DIM_W-1:0];
                CFG_USE_ALPHA:    use_alpha_reg <= cfg_wdata[0];
                default:          use_alpha_reg <= use_alpha_reg;
            endcase
        end
    end

    assign cfg.bit_depth    = bit_depth_reg;
    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;

    // pipeline moves whenever the output register is empty or being taken
    assign enable = !out_valid_reg || pix.ready;

    ippe_slicer u_slicer (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cfg    (cfg),
        .enable (enable),
        .rd     (rd),
        .wr     (wr)
    );

    // reads and writes come from the one slicer step per cycle, in stream order,
    // so a read never meets a write to the same entry in the same cycle
    ippe_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal_ram (
        .clk   (clk),
        .we    (wr.pal_we),
        .waddr (wr.addr),
        .wdata (wr.rgb),
        .re    (rd.en),
        .raddr (rd.index[PAL_ADDR_W-1:0]),
        .rdata (pal_rdata)
    );

    ippe_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_ENTRIES)
    ) u_alpha_ram (
        .clk   (clk),
        .we    (wr.alpha_we),
        .waddr (wr.addr),
        .wdata (wr.alpha),
        .re    (rd.en),
        .raddr (rd.index[PAL_ADDR_W-1:0]),
        .rdata (alpha_rdata)
    );

    // alpha entry valid flags, an unwritten entry reads 255
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_vld_reg <= '0;
        end
        else if (wr.alpha_we)
        begin
            alpha_vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (enable)
        begin
            s1_valid_next  = rd.en;
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            s1_in_range_reg <= rd.in_range;
            s1_alpha_ok_reg <= use_alpha_reg && rd.in_range
                               && alpha_vld_reg[rd.index[PAL_ADDR_W-1:0]];
            s1_last_reg     <= rd.last_of_byte;
            s1_rend_reg     <= rd.row_end;
            s1_fend_reg     <= rd.frame_end;
        end
        if (enable && s1_valid_reg)
        begin
            out_rgb_reg   <= s1_in_range_reg ? pal_rdata : 24'd0;
            out_alpha_reg <= s1_alpha_ok_reg ? alpha_rdata :
                             (use_alpha_reg && s1_in_range_reg ? 8'hFF : 8'hFF);
            out_last_reg  <= s1_last_reg;
            out_rend_reg  <= s1_rend_reg;
            out_fend_reg  <= s1_fend_reg;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_rgb    = out_rgb_reg;
    assign pix.pixel_alpha  = out_alpha_reg;
    assign pix.last_of_byte = out_last_reg;
    assign pix.row_end      = out_rend_reg;
    assign pix.frame_end    = out_fend_reg;

    // a lookup is only started when its data has a place to go
    a_read_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        rd.en |-> enable)
        else $error("ram read issued while pipeline stalled");

    // ram data of a stalled word must not be overwritten
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !enable) |=> (s1_valid_reg && $stable(pal_rdata)))
        else $error("stalled lookup lost its ram data");

    // the frame ends only on a row end, a row ends only on a byte end
    a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.frame_end) |-> pix.row_end)
        else $error("frame end without row end");

    a_row_in_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.row_end) |-> pix.last_of_byte)
        else $error("row end without last of byte");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of indexed_pixel_palette_expander: clocked driver and monitor
// depends on ippe_pkg, ippe_req_if, ippe_pix_if and the rtl of the expander
module testbench;
    import ippe_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PCT       = 23;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_WORDS    = 22;
    localparam int ROW_CHUNK      = 12;
    localparam int MAX_REPORTS    = 40;

    // one input word as queued for the driver
    typedef struct packed {
        req_type_e   kind;
        logic [7:0]  entry;
        logic [23:0] rgb;
        logic [7:0]  alpha;
        logic [7:0]  data;
    } req_word_t;

    // one expanded pixel as it leaves the block
    typedef struct packed {
        logic [23:0] rgb;
        logic [7:0]  alpha;
        logic        last_of_byte;
        logic        row_end;
        logic        frame_end;
    } pixel_t;

    // position in the scanline stream
    typedef struct packed {
        logic [12:0] col;
        logic [12:0] row;
        logic        awaiting_filter;
        logic        dropped;
    } scan_pos_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ippe_req_if req();
    ippe_pix_if pix();

    indexed_pixel_palette_expander dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .pix       (pix),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // register copies, shared by the live predictor and the stimulus planner
    logic [3:0]  cfg_depth;
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic        cfg_alpha;

    // live copy of the block state, advanced on every accepted word
    logic [23:0] color_table [PALETTE_ENTRIES];
    logic [7:0]  opacity_table [PALETTE_ENTRIES];
    scan_pos_t   live_pos;

    // planner copy: only the stream position and which palette entries are loaded
    scan_pos_t   plan_pos;
    bit          plan_loaded [PALETTE_ENTRIES];

    req_word_t   words_pending [$];
    pixel_t      pixels_due [$];
    req_word_t   on_bus;

    int          mismatches = 0;
    int          quiet_cycles = 0;
    logic        calm;
    logic        hold_req;
    logic        hold_taken;
    int          hold_left;

    // depths other than 1, 2 and 4 act as 8
    function automatic int depth_now();
        if (cfg_depth == 4'd1 || cfg_depth == 4'd2 || cfg_depth == 4'd4)
            return int'(cfg_depth);
        return 8;
    endfunction

    // walk one stream byte through the row geometry; returns the number of index
    // slots consumed, with each slot's index and its row and frame end flags
    function automatic int slice_byte(inout scan_pos_t p, input logic [7:0] b,
                                      output logic [7:0][7:0] ix, output logic [7:0] re,
                                      output logic [7:0] fe);
        int d;
        int w;
        int h;
        int n;
        ix = '0;
        re = '0;
        fe = '0;
        n  = 0;
        // filter byte opens the row, nonzero filter drops it
        if (p.awaiting_filter) begin
            p.awaiting_filter = 1'b0;
            p.dropped         = (b != 8'h00);
            p.col             = '0;
            return 0;
        end
        d = depth_now();
        // width clamps to 1..MAX_WIDTH, zero height acts as one
        w = (cfg_width == 13'd0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
        h = (cfg_height == 13'd0) ? 1 : int'(cfg_height);
        for (int s = 0; s < 8 / d; s++) begin
            ix[s] = 8'((b >> (8 - d * (s + 1))) & ((1 << d) - 1));
            re[s] = (int'(p.col) + 1 >= w);
            fe[s] = re[s] && (int'(p.row) + 1 >= h);
            n++;
            if (re[s]) begin
                // padding bits after the row end are thrown away
                p.col             = '0;
                p.awaiting_filter = 1'b1;
                p.row             = fe[s] ? 13'd0 : p.row + 13'd1;
                break;
            end
            p.col = p.col + 13'd1;
        end
        return n;
    endfunction

    // apply one accepted word to the live state and queue the pixels it yields
    task automatic expand_word(input req_word_t wd);
        logic [7:0][7:0] ix;
        logic [7:0]      re;
        logic [7:0]      fe;
        int              n;
        pixel_t          px;
        case (wd.kind)
            REQ_PAL:
                if (wd.entry < PALETTE_ENTRIES) color_table[wd.entry] = wd.rgb;
            REQ_ALPHA:
                if (wd.entry < PALETTE_ENTRIES) opacity_table[wd.entry] = wd.alpha;
            REQ_DATA: begin
                n = slice_byte(live_pos, wd.data, ix, re, fe);
                // dropped rows still walk the geometry but emit nothing
                if (!live_pos.dropped) begin
                    for (int s = 0; s < n; s++) begin
                        px.rgb          = (ix[s] < PALETTE_ENTRIES) ? color_table[ix[s]] : 24'h0;
                        px.alpha        = (ix[s] < PALETTE_ENTRIES && cfg_alpha) ?
                                          opacity_table[ix[s]] : 8'hFF;
                        px.last_of_byte = (s == n - 1);
                        px.row_end      = re[s];
                        px.frame_end    = fe[s];
                        pixels_due.push_back(px);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic req_word_t make_word(req_type_e k, logic [7:0] e, logic [23:0] c,
                                            logic [7:0] a, logic [7:0] b);
        req_word_t wd;
        wd.kind  = k;
        wd.entry = e;
        wd.rgb   = c;
        wd.alpha = a;
        wd.data  = b;
        return wd;
    endfunction

    // queue a word and keep the planner in step with it
    task automatic plan_word(input req_word_t wd);
        logic [7:0][7:0] ix;
        logic [7:0]      re;
        logic [7:0]      fe;
        words_pending.push_back(wd);
        if (wd.kind == REQ_PAL) plan_loaded[wd.entry] = 1'b1;
        if (wd.kind == REQ_DATA) void'(slice_byte(plan_pos, wd.data, ix, re, fe));
    endtask

    // up to chunk data bytes of a row, opening a new one first if needed;
    // kept rows only use loaded palette entries, padding and dropped bytes are random
    task automatic queue_row(input bit keep, input int chunk);
        req_word_t       wd;
        scan_pos_t       probe;
        logic [7:0][7:0] ix;
        logic [7:0]      re;
        logic [7:0]      fe;
        int              n;
        int              d;
        int              sh;
        int              pick;
        if (plan_pos.awaiting_filter)
            plan_word(make_word(REQ_DATA, $urandom, $urandom, $urandom,
                                keep ? 8'h00 : 8'($urandom_range(1, 255))));
        for (int k = 0; k < chunk && !plan_pos.awaiting_filter; k++) begin
            wd = make_word(REQ_DATA, $urandom, $urandom, $urandom, $urandom);
            if (!plan_pos.dropped) begin
                probe = plan_pos;
                n     = slice_byte(probe, 8'h00, ix, re, fe);
                d     = depth_now();
                for (int s = 0; s < n; s++) begin
                    pick = $urandom_range(0, (1 << d) - 1);
                    for (int t = 0; t < 4 && !plan_loaded[pick]; t++)
                        pick = $urandom_range(0, (1 << d) - 1);
                    // entries 0 and 1 are always loaded
                    if (!plan_loaded[pick]) pick = $urandom_range(0, 1);
                    sh      = 8 - d * (s + 1);
                    wd.data = (wd.data & ~8'(((1 << d) - 1) << sh)) | 8'(pick << sh);
                end
            end
            plan_word(wd);
            // sprinkle table writes and ignored words between bytes
            case ($urandom_range(0, 15))
                0: plan_word(make_word(REQ_ALPHA, $urandom, $urandom, $urandom, $urandom));
                1: plan_word(make_word(REQ_NONE, $urandom, $urandom, $urandom, $urandom));
                default: ;
            endcase
        end
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [12:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BIT_DEPTH:    cfg_depth  = val[3:0];
            CFG_IMAGE_WIDTH:  cfg_width  = val;
            CFG_IMAGE_HEIGHT: cfg_height = val;
            CFG_USE_ALPHA:    cfg_alpha  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [12:0] d, input logic [12:0] w,
                            input logic [12:0] h, input logic [12:0] a);
        write_reg(CFG_BIT_DEPTH, d);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_USE_ALPHA, a);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender pause: every word taken, every pixel back, then let the unpacker finish
    // whatever silent work (filter, dropped bytes, table writes) is still in flight
    task automatic drain();
        do @(negedge clk);
        while (words_pending.size() != 0 || req.valid || pixels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // driver: offers queued words, idles at random unless in a calm phase
    always @(posedge clk or negedge rst_n) begin : drive_words
        req_word_t nxt;
        if (!rst_n) begin
            req.valid       <= 1'b0;
            req.req_type    <= REQ_PAL;
            req.entry_index <= '0;
            req.entry_rgb   <= '0;
            req.entry_alpha <= '0;
            req.data_byte   <= '0;
        end else begin
            // a word taken at this edge updates the live state
            if (req.valid && req.ready) expand_word(on_bus);
            if (!req.valid || req.ready) begin
                if (words_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt              = words_pending.pop_front();
                    on_bus          <= nxt;
                    req.valid       <= 1'b1;
                    req.req_type    <= nxt.kind;
                    req.entry_index <= nxt.entry;
                    req.entry_rgb   <= nxt.rgb;
                    req.entry_alpha <= nxt.alpha;
                    req.data_byte   <= nxt.data;
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each taken pixel against the oldest one due, drives ready
    always @(posedge clk or negedge rst_n) begin : watch_pixels
        pixel_t got;
        pixel_t want;
        if (!rst_n) begin
            pix.ready  <= 1'b0;
            hold_taken <= 1'b0;
            hold_left  <= 0;
        end else begin
            if (pix.valid && pix.ready) begin
                got = {pix.pixel_rgb, pix.pixel_alpha, pix.last_of_byte, pix.row_end,
                       pix.frame_end};
                if (pixels_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: no pixel expected, actual %h", $time, got);
                end else begin
                    want = pixels_due.pop_front();
                    check_field("pixel_rgb", want.rgb, got.rgb);
                    check_field("pixel_alpha", want.alpha, got.alpha);
                    check_field("last_of_byte", want.last_of_byte, got.last_of_byte);
                    check_field("row_end", want.row_end, got.row_end);
                    check_field("frame_end", want.frame_end, got.frame_end);
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_req && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= LONG_HOLD;
                pix.ready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pix.ready <= 1'b0;
            end else begin
                pix.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no word taken on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (pix.valid && pix.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int r;
        logic [12:0] d;
        logic [12:0] w;
        logic [12:0] h;
        logic [12:0] a;

        // everything known from time zero
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_BIT_DEPTH;
        cfg_wdata       = '0;
        calm            = 1'b0;
        hold_req        = 1'b0;
        req.valid       = 1'b0;
        req.req_type    = REQ_PAL;
        req.entry_index = '0;
        req.entry_rgb   = '0;
        req.entry_alpha = '0;
        req.data_byte   = '0;
        pix.ready       = 1'b0;

        // state after reset
        cfg_depth  = 4'd8;
        cfg_width  = 13'd1;
        cfg_height = 13'd1;
        cfg_alpha  = 1'b0;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            color_table[i]   = 24'h0;
            opacity_table[i] = 8'hFF;
            plan_loaded[i]   = 1'b0;
        end
        live_pos = '{col: 13'd0, row: 13'd0, awaiting_filter: 1'b1, dropped: 1'b0};
        plan_pos = live_pos;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset registers: table extremes, ignored word, one-pixel frame,
        // a dropped row, then a middle index
        plan_word(make_word(REQ_PAL,   8'd0,   24'h000000, 8'h00, 8'h00));
        plan_word(make_word(REQ_PAL,   8'd1,   24'hFFFFFF, 8'hFF, 8'hFF));
        plan_word(make_word(REQ_PAL,   8'd2,   24'hFF0000, 8'h00, 8'h00));
        plan_word(make_word(REQ_PAL,   8'd3,   24'h0000FF, 8'h00, 8'h00));
        plan_word(make_word(REQ_PAL,   8'd15,  24'h0F0F0F, 8'h00, 8'h00));
        plan_word(make_word(REQ_PAL,   8'd85,  24'h555555, 8'h00, 8'h00));
        plan_word(make_word(REQ_PAL,   8'd170, 24'hAAAAAA, 8'h00, 8'h00));
        plan_word(make_word(REQ_PAL,   8'd255, 24'hA5C3E1, 8'h00, 8'h00));
        plan_word(make_word(REQ_PAL,   8'd128, 24'h123456, 8'h00, 8'h00));
        plan_word(make_word(REQ_ALPHA, 8'd1,   24'h000000, 8'h00, 8'h00));
        plan_word(make_word(REQ_ALPHA, 8'd255, 24'h000000, 8'h80, 8'h00));
        plan_word(make_word(REQ_ALPHA, 8'd2,   24'h000000, 8'hFF, 8'h00));
        plan_word(make_word(REQ_NONE,  8'hFF,  24'hFFFFFF, 8'hFF, 8'hFF));
        plan_word(make_word(REQ_DATA,  8'h00,  24'h000000, 8'h00, 8'h00));
        plan_word(make_word(REQ_DATA,  8'h00,  24'h000000, 8'h00, 8'hFF));
        plan_word(make_word(REQ_DATA,  8'h00,  24'h000000, 8'h00, 8'h07));
        plan_word(make_word(REQ_DATA,  8'h00,  24'h000000, 8'h00, 8'h00));
        plan_word(make_word(REQ_DATA,  8'h00,  24'h000000, 8'h00, 8'h00));
        plan_word(make_word(REQ_DATA,  8'h00,  24'h000000, 8'h00, 8'h80));
        drain();

        // directed, 1-bit indices with alpha: a row split over two bytes with padding,
        // then a dropped last row so no frame end shows, then a fresh frame
        set_regs(13'd1, 13'd10, 13'd2, 13'd1);
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'h00));
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'hAA));
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'hC0));
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'hFF));
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'h5A));
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'hFF));
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'h00));
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'h55));
        plan_word(make_word(REQ_DATA, 8'h00, 24'h000000, 8'h00, 8'h40));
        drain();

        // back-pressure: eight pixels per byte while the output holds off
        set_regs(13'd1, 13'd32, 13'd3, 13'd1);
        hold_req <= 1'b1;
        repeat (4) queue_row(1'b1, 100);
        drain();

        // random phases; the first two hit the register extremes and leave the
        // second one to pick up a row cut off mid-way under new registers
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin d = 13'd1;  w = 13'd4096; h = 13'd8191; a = 13'd1; end
                1: begin d = 13'd15; w = 13'd0;    h = 13'd0;    a = 13'd0; end
                default: begin
                    r = $urandom_range(0, 9);
                    d = (r < 8) ? 13'(1 << (r / 2)) : 13'($urandom_range(0, 15));
                    r = $urandom_range(0, 9);
                    w = (r < 7) ? 13'($urandom_range(1, 20)) :
                        (r == 7) ? 13'd0 : (r == 8) ? 13'd4096 : 13'($urandom_range(0, 8191));
                    r = $urandom_range(0, 9);
                    h = (r < 6) ? 13'($urandom_range(1, 4)) :
                        (r == 6) ? 13'd0 : (r == 7) ? 13'd8191 : 13'($urandom_range(1, 6));
                    a = 13'($urandom_range(0, 1));
                end
            endcase
            set_regs(d, w, h, a);
            // one stretch with no idling on either side
            calm <= (p == 5);
            while (words_pending.size() < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    queue_row(1'b1, ROW_CHUNK);
                else if (r < 82)
                    queue_row(1'b0, ROW_CHUNK);
                else if (r < 90)
                    plan_word(make_word(REQ_PAL, $urandom, $urandom, $urandom, $urandom));
                else if (r < 95)
                    plan_word(make_word(REQ_ALPHA, $urandom, $urandom, $urandom, $urandom));
                else
                    plan_word(make_word(REQ_NONE, $urandom, $urandom, $urandom, $urandom));
            end
            drain();
            calm <= 1'b0;
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
